>>> rtl/core/xcfr_pkg.sv
// ----------------------------------------------------------------------------
// xcfr_pkg
// Shared types and constants for the checksummed frame receiver: parse
// phases, event kinds and the result record passed to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package xcfr_pkg;

	// start of frame marker
	localparam logic [7:0] START_BYTE = 8'hAA;

	// event kinds on the result channel
	localparam logic [1:0] EV_PAYLOAD  = 2'd0;
	localparam logic [1:0] EV_END_GOOD = 2'd1;
	localparam logic [1:0] EV_END_BAD  = 2'd2;

	// parse phases, one-hot
	typedef enum logic [5:0] {
		PH_HUNT    = 6'b000001,
		PH_TYPE    = 6'b000010,
		PH_LEN_LO  = 6'b000100,
		PH_LEN_HI  = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_CHECK   = 6'b100000
	} phase_t;

	// one result item with its valid flag
	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [7:0]  frame_type;
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic [15:0] payload_length;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/core/xcfr_parser.sv
// ----------------------------------------------------------------------------
// xcfr_parser
// Frame state machine: hunts for the start byte, collects type and length,
// tags payload bytes and checks the running xor at the checksum byte.
// ----------------------------------------------------------------------------
`default_nettype none

module xcfr_parser
	import xcfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	output result_t         res
);

	phase_t      phase_q, phase_d;
	logic [7:0]  type_q, type_d;
	logic [15:0] length_q, length_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  xor_q, xor_d;
	logic [15:0] count_inc;
	logic [15:0] length_hi;

	assign count_inc = count_q + 16'd1;
	assign length_hi = {rx_byte, length_q[7:0]};

	// next state and result for the byte in hand
	always_comb begin
		phase_d  = phase_q;
		type_d   = type_q;
		length_d = length_q;
		count_d  = count_q;
		xor_d    = xor_q;
		res      = '0;
		res.frame_type     = type_q;
		res.data_byte      = rx_byte;
		res.payload_length = length_q;
		unique case (phase_q)
			PH_TYPE: begin
				type_d  = rx_byte;
				xor_d   = rx_byte;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				length_d = {8'd0, rx_byte};
				xor_d    = xor_q ^ rx_byte;
				phase_d  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				length_d = length_hi;
				xor_d    = xor_q ^ rx_byte;
				count_d  = '0;
				phase_d  = (length_hi == 16'd0) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				xor_d          = xor_q ^ rx_byte;
				res.valid      = 1'b1;
				res.kind       = EV_PAYLOAD;
				res.byte_index = count_q;
				count_d        = count_inc;
				if (count_inc == length_q) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				res.valid = 1'b1;
				res.kind  = (rx_byte == xor_q) ? EV_END_GOOD : EV_END_BAD;
				phase_d   = PH_HUNT;
			end
			default: begin
				// hunting: drop everything but the start byte
				if (rx_byte == START_BYTE) begin
					phase_d = PH_TYPE;
					xor_d   = '0;
					count_d = '0;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			type_q   <= '0;
			length_q <= '0;
			count_q  <= '0;
			xor_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			type_q   <= type_d;
			length_q <= length_d;
			count_q  <= count_d;
			xor_q    <= xor_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/xcfr_out_reg.sv
// ----------------------------------------------------------------------------
// xcfr_out_reg
// Result register on the output channel; holds an item while the receiver
// stalls and reports whether it can take a new one.
// ----------------------------------------------------------------------------
`default_nettype none

module xcfr_out_reg
	import xcfr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         load,
	input  wire result_t      res,
	output logic              free,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [1:0]        event_kind,
	output logic [7:0]        frame_type,
	output logic [7:0]        data_byte,
	output logic [15:0]       byte_index,
	output logic [15:0]       payload_length
);

	logic    valid_q;
	result_t data_q;

	// slot is free when empty or being taken this cycle
	assign free = !valid_q || !out_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res.valid;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load && res.valid) begin
			data_q <= res;
		end
	end

	assign out_valid      = valid_q;
	assign event_kind     = data_q.kind;
	assign frame_type     = data_q.frame_type;
	assign data_byte      = data_q.data_byte;
	assign byte_index     = data_q.byte_index;
	assign payload_length = data_q.payload_length;

endmodule

`default_nettype wire

>>> rtl/core/xor_checked_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_unit
// Cut-through deframer for a byte-serial link with an xor checksum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, rx_byte) takes one received byte per
//   item. Bytes are dropped until the start byte 0xAA; then come the type,
//   a little-endian 16-bit length, the payload and one checksum byte.
//   Output channel (out_valid, out_stall, ...) gives one item per payload
//   byte (kind 0, tagged with type, index and length) and one end item per
//   frame, kind 1 for a good checksum and kind 2 for a bad one; downstream
//   logic discards a frame that ends bad.
//   A byte is captured in the input register at acceptance and is parsed
//   once the result slot is free; its result is then loaded into the
//   output register, which drives out_valid for payload and end items.
//   Throughput: one byte per cycle while no stalled result blocks the slot,
//   set by the frame state update; the output register lets a new byte be
//   taken while a result waits.
//   Reset (arst_n low) empties both registers and returns the parser to
//   hunting. While out_stall holds a waiting result, a byte that is ready
//   to be parsed is held and in_stall is raised until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_checked_frame_receiver_unit
	import xcfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       event_kind,
	output logic [7:0]       frame_type,
	output logic [7:0]       data_byte,
	output logic [15:0]      byte_index,
	output logic [15:0]      payload_length
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       free;
	logic       step;
	result_t    res;

	// parse the held byte when the result slot can take its outcome
	assign step     = valid_s1 && free;
	assign in_stall = valid_s1 && !free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	xcfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.res     (res)
	);

	xcfr_out_reg u_out_reg (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (step),
		.res            (res),
		.free           (free),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.event_kind     (event_kind),
		.frame_type     (frame_type),
		.data_byte      (data_byte),
		.byte_index     (byte_index),
		.payload_length (payload_length)
	);

endmodule

`default_nettype wire

>>> tb/xcfr_frame_monitor.sv
// ----------------------------------------------------------------------------
// xcfr_frame_monitor
// Watches both channels of the frame receiver. It keeps its own copy of the
// parser state and, for every byte taken, works out the payload or end
// event due. Each accepted output item is compared with the oldest waiting
// event, and faults are counted for the testbench top.
// ----------------------------------------------------------------------------
`default_nettype none

module xcfr_frame_monitor
	import xcfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [1:0]  event_kind,
	input  wire logic [7:0]  frame_type,
	input  wire logic [7:0]  data_byte,
	input  wire logic [15:0] byte_index,
	input  wire logic [15:0] payload_length,
	output int               mismatch_count,
	output int               events_waiting,
	output int               payload_seen,
	output int               good_ends,
	output int               bad_ends
);

	timeunit 1ns;
	timeprecision 1ps;

	// shadow parser state
	phase_t      parse_ph;
	logic [7:0]  frm_type;
	logic [15:0] frm_len;
	logic [15:0] pay_cnt;
	logic [7:0]  xor_acc;

	// events still owed by the block, oldest first
	result_t expected_events[$];

	initial begin
		mismatch_count = 0;
		events_waiting = 0;
		payload_seen   = 0;
		good_ends      = 0;
		bad_ends       = 0;
	end

	// count a fault, report only the first few
	task automatic note_fault(input string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// advance the shadow parser by one byte and queue any event it causes
	task automatic parse_rx_byte(input logic [7:0] b);
		result_t ev;
		ev                = '0;
		ev.valid          = 1'b1;
		ev.frame_type     = frm_type;
		ev.payload_length = frm_len;
		case (parse_ph)
			PH_TYPE: begin
				frm_type = b;
				xor_acc  = b;
				parse_ph = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				frm_len  = {8'h00, b};
				xor_acc  = xor_acc ^ b;
				parse_ph = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				frm_len  = {b, frm_len[7:0]};
				xor_acc  = xor_acc ^ b;
				pay_cnt  = 16'd0;
				// zero-length frame goes straight to the checksum
				if (frm_len == 16'd0)
					parse_ph = PH_CHECK;
				else
					parse_ph = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				xor_acc           = xor_acc ^ b;
				ev.kind           = EV_PAYLOAD;
				ev.data_byte      = b;
				ev.byte_index     = pay_cnt;
				ev.payload_length = frm_len;
				expected_events.push_back(ev);
				pay_cnt = pay_cnt + 16'd1;
				if (pay_cnt == frm_len)
					parse_ph = PH_CHECK;
			end
			PH_CHECK: begin
				if (b == xor_acc)
					ev.kind = EV_END_GOOD;
				else
					ev.kind = EV_END_BAD;
				ev.data_byte      = b;
				ev.byte_index     = 16'd0;
				ev.payload_length = frm_len;
				expected_events.push_back(ev);
				parse_ph = PH_HUNT;
			end
			default: begin
				// hunting: anything but the start byte is dropped
				if (b == START_BYTE) begin
					parse_ph = PH_TYPE;
					xor_acc  = 8'h00;
					pay_cnt  = 16'd0;
				end else begin
					parse_ph = PH_HUNT;
				end
			end
		endcase
	endtask

	// compare output items first, then take the input byte of this edge
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			parse_ph = PH_HUNT;
			frm_type = 8'h00;
			frm_len  = 16'd0;
			pay_cnt  = 16'd0;
			xor_acc  = 8'h00;
			expected_events.delete();
			events_waiting = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					note_fault($sformatf("unexpected item kind %0d type %02h data %02h",
						event_kind, frame_type, data_byte));
				end else begin
					want = expected_events.pop_front();
					if (event_kind != want.kind || frame_type != want.frame_type ||
							data_byte != want.data_byte || byte_index != want.byte_index ||
							payload_length != want.payload_length)
						note_fault($sformatf({"expected kind %0d type %02h data %02h ",
							"index %0d length %0d, got kind %0d type %02h data %02h ",
							"index %0d length %0d"},
							want.kind, want.frame_type, want.data_byte, want.byte_index,
							want.payload_length, event_kind, frame_type, data_byte,
							byte_index, payload_length));
					case (event_kind)
						EV_PAYLOAD:  payload_seen++;
						EV_END_GOOD: good_ends++;
						default:     bad_ends++;
					endcase
				end
			end
			if (in_valid && !in_stall)
				parse_rx_byte(rx_byte);
			events_waiting = expected_events.size();
		end
	end

endmodule

`default_nettype wire

>>> tb/xor_checked_frame_receiver_unit_test.sv
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_unit_test
// Drives byte streams into the frame receiver: a few hand-built frames,
// then random well-formed frames mixed with line noise and cut-short
// frames, one frame past 255 bytes and a final stretch at full rate.
// Both sides idle at random and the output is held off once for a long
// stretch. A separate monitor predicts and checks every output item.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_checked_frame_receiver_unit_test;

	import xcfr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int LONG_HOLD   = 64;
	localparam int BUSY_BYTES  = 420;
	localparam int CALM_BYTES  = 240;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  rx_byte  = 8'h00;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  event_kind;
	logic [7:0]  frame_type;
	logic [7:0]  data_byte;
	logic [15:0] byte_index;
	logic [15:0] payload_length;

	int mismatch_count;
	int events_waiting;
	int payload_seen;
	int good_ends;
	int bad_ends;

	// shared idling odds: one chance in idle_odds per byte sent and per receiver stall decision, 0 turns idling off
	int unsigned idle_odds = 3;
	int          sent_items = 0;
	int          cycle_count = 0;
	bit          long_hold_req = 1'b0;
	bit          long_hold_done = 1'b0;

	xor_checked_frame_receiver_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.event_kind     (event_kind),
		.frame_type     (frame_type),
		.data_byte      (data_byte),
		.byte_index     (byte_index),
		.payload_length (payload_length)
	);

	xcfr_frame_monitor u_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.event_kind     (event_kind),
		.frame_type     (frame_type),
		.data_byte      (data_byte),
		.byte_index     (byte_index),
		.payload_length (payload_length),
		.mismatch_count (mismatch_count),
		.events_waiting (events_waiting),
		.payload_seen   (payload_seen),
		.good_ends      (good_ends),
		.bad_ends       (bad_ends)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		int burst;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req && !long_hold_done) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall <= 1'b0;
				long_hold_done = 1'b1;
			end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				burst = $urandom_range(1, 6);
				out_stall <= 1'b1;
				repeat (burst - 1) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// offer one byte, possibly after an idle burst, and wait until it is taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		sent_items++;
	endtask

	// payload content, with the start byte showing up now and then
	function automatic logic [7:0] pick_payload();
		if ($urandom_range(0, 9) == 0)
			return START_BYTE;
		return 8'($urandom_range(0, 255));
	endfunction

	// mostly short payloads, a few zero-length and a few past 255 bytes
	function automatic logic [15:0] pick_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 16'd0;
		if (r < 80)
			return 16'($urandom_range(1, 8));
		if (r < 97)
			return 16'($urandom_range(9, 40));
		return 16'($urandom_range(256, 300));
	endfunction

	// complete frame with random payload; corrupt spoils the checksum
	task automatic send_frame(input logic [7:0] ftype, input logic [15:0] flen,
			input bit corrupt);
		logic [7:0] sum;
		logic [7:0] b;
		int         k;
		sum = ftype ^ flen[7:0] ^ flen[15:8];
		send_byte(START_BYTE);
		send_byte(ftype);
		send_byte(flen[7:0]);
		send_byte(flen[15:8]);
		for (k = 0; k < int'(flen); k++) begin
			b   = pick_payload();
			sum = sum ^ b;
			send_byte(b);
		end
		if (corrupt)
			sum = sum ^ 8'($urandom_range(1, 255));
		send_byte(sum);
	endtask

	// random mix of frames, line noise and cut-short frames
	task automatic send_random_traffic(input int count, input bit vary_idling);
		int          stop_at;
		int          next_switch;
		int unsigned pick;
		int          n;
		int          k;
		logic [7:0]  b;
		logic [7:0]  lo;
		stop_at     = sent_items + count;
		next_switch = sent_items + 60;
		while (sent_items < stop_at) begin
			if (vary_idling && sent_items >= next_switch) begin
				idle_odds   = ($urandom_range(0, 3) == 0) ? 0 : 4;
				next_switch = sent_items + 60;
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_frame(8'($urandom_range(0, 255)), pick_length(),
					$urandom_range(0, 4) == 0);
			end else if (pick < 85) begin
				// line noise, kept clear of the start byte
				n = $urandom_range(1, 4);
				for (k = 0; k < n; k++) begin
					b = 8'($urandom_range(0, 255));
					if (b == START_BYTE)
						b = 8'h55;
					send_byte(b);
				end
			end else begin
				// frame cut short: whatever follows fills the payload
				lo = 8'($urandom_range(1, 12));
				send_byte(START_BYTE);
				send_byte(8'($urandom_range(0, 255)));
				send_byte(lo);
				send_byte(8'h00);
				n = $urandom_range(0, int'(lo) - 1);
				for (k = 0; k < n; k++)
					send_byte(pick_payload());
			end
		end
	endtask

	// stimulus and verdict
	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// noise before any frame
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h55);
		// zero-length frame, good checksum
		send_byte(START_BYTE); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
		send_byte(8'h00);
		// zero-length frame, bad checksum
		send_byte(START_BYTE); send_byte(8'hFF); send_byte(8'h00); send_byte(8'h00);
		send_byte(8'h00);
		// start byte as type and as payload, good checksum
		send_byte(START_BYTE); send_byte(START_BYTE); send_byte(8'h02); send_byte(8'h00);
		send_byte(START_BYTE); send_byte(8'hFF); send_byte(8'hFD);
		// start byte in the checksum position, bad checksum
		send_byte(START_BYTE); send_byte(8'h01); send_byte(8'h01); send_byte(8'h00);
		send_byte(8'h00); send_byte(START_BYTE);

		// busy part with idling and one long output hold-off
		long_hold_req = 1'b1;
		send_random_traffic(BUSY_BYTES, 1'b1);

		// frame past 255 bytes, so the length high byte counts
		idle_odds = 4;
		send_frame(8'h5A, 16'd260, 1'b0);

		// full-rate tail
		idle_odds = 0;
		send_random_traffic(CALM_BYTES, 1'b0);

		@(negedge clk);
		in_valid <= 1'b0;
		while (events_waiting != 0 || !long_hold_done)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("sent %0d bytes: %0d payload items, %0d good and %0d bad frame ends checked",
			sent_items, payload_seen, good_ends, bad_ends);
		$display("covered noise, zero-length, cut-short and long frames, stray start bytes");
		if (mismatch_count == 0 && events_waiting == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

>>> xor_checked_frame_receiver_unit.f
rtl/core/xcfr_pkg.sv
rtl/core/xcfr_parser.sv
rtl/core/xcfr_out_reg.sv
rtl/core/xor_checked_frame_receiver_unit.sv
tb/xcfr_frame_monitor.sv
tb/xor_checked_frame_receiver_unit_test.sv
